// ----- rtl/tcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Toroidal circle map painter package
// Shared field widths, opcode and register codes, reset values and the
// payload structs of the request and response channels.
// ----------------------------------------------------------------------------
package tcmp_pkg;

   localparam int OPCODE_W    = 2;
   localparam int COORD_W     = 10;
   localparam int RADIUS_W    = 6;
   localparam int VALUE_W     = 16;
   localparam int READ_IDX_W  = 7;
   localparam int CELL_W      = 32;
   localparam int COUNT_W     = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam int MAX_ROWS_DEFAULT = 128;
   localparam int MAX_COLS_DEFAULT = 128;

   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMBINE_MODE = 2'd2;

   localparam logic [CSR_DATA_W-1:0] GRID_ROWS_RESET = 8'd128;
   localparam logic [CSR_DATA_W-1:0] GRID_COLS_RESET = 8'd128;

   typedef struct packed {
      logic [OPCODE_W-1:0]          opcode;
      logic [COORD_W-1:0]           center_x;
      logic [COORD_W-1:0]           center_y;
      logic [RADIUS_W-1:0]          radius;
      logic signed [VALUE_W-1:0]    circle_value;
      logic [READ_IDX_W-1:0]        read_row;
      logic [READ_IDX_W-1:0]        read_col;
   } req_payload_type;

   typedef struct packed {
      logic signed [CELL_W-1:0]     cell_value;
      logic [COUNT_W-1:0]           cells_touched;
   } rsp_payload_type;

endpackage

// ----- rtl/tcmp_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Serial remainder unit
// Restoring remainder of an unsigned dividend by a nonzero divisor, one
// dividend bit per cycle. The remainder holds until the next start.
// ----------------------------------------------------------------------------
module tcmp_mod_unit
   import tcmp_pkg::*;
#(
   parameter int DIVIDEND_W = 15,
   parameter int DIVISOR_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W-1:0]  rem_in;

   // Bring down the next dividend bit and subtract when the divisor fits.
   assign trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign rem_in = (trial >= {1'b0, divisor}) ? DIVISOR_W'(trial - {1'b0, divisor})
                                              : DIVISOR_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
         quo_ff  <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_ff << 1;
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/toroidal_circle_map_painter_core.sv -----
// ----------------------------------------------------------------------------
// Toroidal circle map painter
// Grid of signed 32-bit cells on a torus with clear, filled-circle draw
// and single-cell read commands.
// ----------------------------------------------------------------------------
// Usage: an item on the req_ channel carries one command. It is taken when
// req_valid is high and req_stall is low; req_stall stays high while a
// command is in progress, so the block works on one item at a time. Every
// item gives exactly one result item on the rsp_ channel, held in an output
// register until rsp_stall is low, so the next item is taken while a
// result still waits. The csr_ port writes grid_rows, grid_cols and
// combine_mode; the user must do so only while the block is idle, and
// the block itself does not enforce this. A read goes through S_READ and
// S_READ_WAIT to its result. A draw first wraps the start coordinates of
// its box with the remainder units, one step per bit of the shifted start
// coordinate (15 bits at the default size), then sets up and scans every
// cell of the 2r by 2r box, one cell per cycle, through a read-modify-write
// pipeline on the grid memory, which has one write port and one read port.
// A draw of radius zero skips the scan. A clear sweeps the memory one word
// per cycle. After reset the same sweep runs with req_stall high and gives
// no result.
// A stalled receiver only holds the result; the next command may finish
// its work and then waits until the output register is free.
// ----------------------------------------------------------------------------
module toroidal_circle_map_painter_core
   import tcmp_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Widths of grid sizes (able to hold the size itself) and of coordinates.
   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // The start coordinate center - radius is made non-negative by adding
   // 2^RADIUS_W times the grid size, which leaves its remainder unchanged.
   localparam int ROW_DIV_W = (((RNW + RADIUS_W) > COORD_W) ? (RNW + RADIUS_W) : COORD_W) + 1;
   localparam int COL_DIV_W = (((CNW + RADIUS_W) > COORD_W) ? (CNW + RADIUS_W) : COORD_W) + 1;
   localparam int DW    = RADIUS_W + 2;
   localparam int SQW   = 2 * DW;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_READ,
      S_READ_WAIT,
      S_MOD_START,
      S_MOD_WAIT,
      S_BASE,
      S_DRAW,
      S_DRAIN,
      S_RESULT
   } state_type;

   // Square of a small signed offset.
   function automatic logic [SQW-1:0] sq_mag(input logic signed [DW-1:0] d);
      logic [DW-1:0] m;
      m = d[DW-1] ? DW'(-d) : DW'(d);
      return SQW'(m) * SQW'(m);
   endfunction

   // Configuration registers.
   logic [CSR_DATA_W-1:0]   grid_rows_ff;
   logic [CSR_DATA_W-1:0]   grid_cols_ff;
   logic                    combine_mode_ff;

   // Control state.
   state_type               state_ff;
   logic                    sweep_init_ff;
   logic [AW-1:0]           sweep_addr_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_payload_ff;
   rsp_payload_type         res_ff;

   // Latched command.
   logic [COORD_W-1:0]      cx_ff;
   logic [COORD_W-1:0]      cy_ff;
   logic [RADIUS_W-1:0]     r_ff;
   logic [CELL_W-1:0]       val_ff;
   logic [AW-1:0]           rd_addr_ff;
   logic                    rd_in_range_ff;

   // Scan state.
   logic signed [DW-1:0]    dr_ff;
   logic signed [DW-1:0]    dc_ff;
   logic [SQW-1:0]          dr_sq_ff;
   logic [SQW-1:0]          rsq_ff;
   logic [RIW-1:0]          mrow_ff;
   logic [CIW-1:0]          mcol_ff;
   logic [CIW-1:0]          mcol0_ff;
   logic [AW-1:0]           row_base_ff;
   logic [COUNT_W-1:0]      cnt_ff;

   // Read-modify-write pipeline.
   logic                    s1_valid_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic [CELL_W-1:0]       fwd_data_ff;

   // Grid memory.
   logic [CELL_W-1:0]       grid_mem [DEPTH];
   logic [CELL_W-1:0]       mem_rd_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_wa;
   logic [CELL_W-1:0]       mem_wd;
   logic [AW-1:0]           mem_ra;

   logic [RNW-1:0]          rows_eff;
   logic [CNW-1:0]          cols_eff;
   logic                    req_accept;
   logic                    out_free;
   logic signed [DW-1:0]    r_signed;
   logic signed [DW-1:0]    d_first;
   logic signed [DW-1:0]    dr_nxt;
   logic signed [DW-1:0]    dc_nxt;
   logic [AW-1:0]           scan_addr;
   logic                    scan_hit;
   logic                    row_wrap;
   logic                    col_wrap;
   logic [CELL_W-1:0]       old_value;
   logic [CELL_W-1:0]       new_value;

   logic                    mod_start;
   logic [ROW_DIV_W-1:0]    row_dividend;
   logic [COL_DIV_W-1:0]    col_dividend;
   logic                    row_busy;
   logic                    col_busy;
   logic [RNW-1:0]          row_rem;
   logic [CNW-1:0]          col_rem;

   // A size of zero counts as one, a size above the memory counts as the
   // memory's size.
   assign rows_eff = (grid_rows_ff == '0) ? RNW'(1) :
                     (32'(grid_rows_ff) > 32'(MAX_ROWS)) ? RNW'(MAX_ROWS) :
                     RNW'(grid_rows_ff);
   assign cols_eff = (grid_cols_ff == '0) ? CNW'(1) :
                     (32'(grid_cols_ff) > 32'(MAX_COLS)) ? CNW'(MAX_COLS) :
                     CNW'(grid_cols_ff);

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Start coordinates of the box, wrapped onto the torus by the remainder
   // units.
   assign mod_start    = (state_ff == S_MOD_START);
   assign row_dividend = ROW_DIV_W'((32'(rows_eff) << RADIUS_W) + 32'(cx_ff) - 32'(r_ff));
   assign col_dividend = COL_DIV_W'((32'(cols_eff) << RADIUS_W) + 32'(cy_ff) - 32'(r_ff));

   tcmp_mod_unit #(
      .DIVIDEND_W (ROW_DIV_W),
      .DIVISOR_W  (RNW)
   ) u_row_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (row_dividend),
      .divisor   (rows_eff),
      .busy      (row_busy),
      .remainder (row_rem)
   );

   tcmp_mod_unit #(
      .DIVIDEND_W (COL_DIV_W),
      .DIVISOR_W  (CNW)
   ) u_col_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (col_dividend),
      .divisor   (cols_eff),
      .busy      (col_busy),
      .remainder (col_rem)
   );

   // Scan step. The offsets from the circle's center cell run from 1-r up
   // to r in both directions; the wrapped row and column advance with them.
   assign r_signed  = $signed({2'b00, r_ff});
   assign d_first   = DW'(1) - r_signed;
   assign dr_nxt    = dr_ff + DW'(1);
   assign dc_nxt    = dc_ff + DW'(1);
   assign scan_addr = row_base_ff + AW'(mcol_ff);
   assign scan_hit  = (state_ff == S_DRAW) && ((dr_sq_ff + sq_mag(dc_ff)) < rsq_ff);
   assign row_wrap  = ((RNW'(mrow_ff) + RNW'(1)) == rows_eff);
   assign col_wrap  = ((CNW'(mcol_ff) + CNW'(1)) == cols_eff);

   // A read issued in the cycle of the previous write to the same cell
   // returns the old word; the forwarding register supplies the new one.
   assign old_value = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : mem_rd_ff;
   assign new_value = combine_mode_ff ? val_ff : (old_value + val_ff);

   assign mem_we = (state_ff == S_SWEEP) || s1_valid_ff;
   assign mem_wa = (state_ff == S_SWEEP) ? sweep_addr_ff : s1_addr_ff;
   assign mem_wd = (state_ff == S_SWEEP) ? '0 : new_value;
   assign mem_ra = (state_ff == S_READ) ? rd_addr_ff : scan_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= grid_mem[mem_ra];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff    <= GRID_ROWS_RESET;
         grid_cols_ff    <= GRID_COLS_RESET;
         combine_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_ROWS: begin
               grid_rows_ff <= csr_write_data;
            end
            CSR_GRID_COLS: begin
               grid_cols_ff <= csr_write_data;
            end
            CSR_COMBINE_MODE: begin
               combine_mode_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer, pipeline registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_init_ff <= 1'b1;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= scan_hit;
         s1_addr_ff   <= scan_addr;
         fwd_valid_ff <= s1_valid_ff;
         fwd_addr_ff  <= s1_addr_ff;
         fwd_data_ff  <= new_value;

         // When a waiting result leaves in the cycle the next one is ready,
         // S_RESULT below loads the output register instead.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_SWEEP: begin
               if (sweep_addr_ff == AW'(DEPTH - 1)) begin
                  res_ff   <= '0;
                  state_ff <= sweep_init_ff ? S_IDLE : S_RESULT;
               end else begin
                  sweep_addr_ff <= sweep_addr_ff + AW'(1);
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  cx_ff          <= req_payload.center_x;
                  cy_ff          <= req_payload.center_y;
                  r_ff           <= req_payload.radius;
                  val_ff         <= CELL_W'(req_payload.circle_value);
                  rd_in_range_ff <= (32'(req_payload.read_row) < 32'(MAX_ROWS)) &&
                                    (32'(req_payload.read_col) < 32'(MAX_COLS));
                  rd_addr_ff     <= AW'(32'(req_payload.read_row) * 32'(MAX_COLS) +
                                        32'(req_payload.read_col));
                  res_ff         <= '0;
                  cnt_ff         <= '0;
                  case (req_payload.opcode)
                     OP_CLEAR: begin
                        sweep_init_ff <= 1'b0;
                        sweep_addr_ff <= '0;
                        state_ff      <= S_SWEEP;
                     end
                     OP_DRAW: begin
                        // A zero radius leaves an empty box.
                        state_ff <= (req_payload.radius == '0) ? S_RESULT : S_MOD_START;
                     end
                     OP_READ: begin
                        state_ff <= S_READ;
                     end
                     default: begin
                        state_ff <= S_RESULT;
                     end
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_READ_WAIT;
            end
            S_READ_WAIT: begin
               res_ff.cell_value <= rd_in_range_ff ? mem_rd_ff : '0;
               state_ff          <= S_RESULT;
            end
            S_MOD_START: begin
               state_ff <= S_MOD_WAIT;
            end
            S_MOD_WAIT: begin
               if (!row_busy && !col_busy) begin
                  mrow_ff  <= RIW'(row_rem);
                  mcol_ff  <= CIW'(col_rem);
                  mcol0_ff <= CIW'(col_rem);
                  state_ff <= S_BASE;
               end
            end
            S_BASE: begin
               row_base_ff <= AW'(32'(mrow_ff) * 32'(MAX_COLS));
               dr_ff       <= d_first;
               dc_ff       <= d_first;
               dr_sq_ff    <= sq_mag(d_first);
               rsq_ff      <= SQW'(r_ff) * SQW'(r_ff);
               state_ff    <= S_DRAW;
            end
            S_DRAW: begin
               if (scan_hit) begin
                  cnt_ff <= cnt_ff + COUNT_W'(1);
               end
               if (dc_ff == r_signed) begin
                  dc_ff   <= d_first;
                  mcol_ff <= mcol0_ff;
                  if (dr_ff == r_signed) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     dr_ff    <= dr_nxt;
                     dr_sq_ff <= sq_mag(dr_nxt);
                     if (row_wrap) begin
                        mrow_ff     <= '0;
                        row_base_ff <= '0;
                     end else begin
                        mrow_ff     <= mrow_ff + RIW'(1);
                        row_base_ff <= row_base_ff + AW'(MAX_COLS);
                     end
                  end
               end else begin
                  dc_ff   <= dc_nxt;
                  mcol_ff <= col_wrap ? '0 : (mcol_ff + CIW'(1));
               end
            end
            S_DRAIN: begin
               // The last touched cell is written back in this cycle.
               res_ff.cells_touched <= cnt_ff;
               state_ff             <= S_RESULT;
            end
            S_RESULT: begin
               if (out_free) begin
                  rsp_payload_ff <= res_ff;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
